@@ src/cldc_pkg.sv @@
// ----------------------------------------------------------------------------
// cldc_pkg
// Shared constants and types for the code lock door controller: phase codes,
// option bytes, register indexes, register reset values and the result record.
// ----------------------------------------------------------------------------
package cldc_pkg;

  // Length of one code entry in characters
  localparam int CodeLenDef = 5;

  // Field widths
  localparam int DataW  = 8;
  localparam int PhaseW = 4;
  localparam int TickW  = 8;
  localparam int WrongW = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 8;

  // Controller phases
  localparam logic [PhaseW-1:0] PH_SET1   = 4'd0;
  localparam logic [PhaseW-1:0] PH_SET2   = 4'd1;
  localparam logic [PhaseW-1:0] PH_OPTION = 4'd2;
  localparam logic [PhaseW-1:0] PH_CHECK  = 4'd3;
  localparam logic [PhaseW-1:0] PH_OPEN   = 4'd4;
  localparam logic [PhaseW-1:0] PH_HOLD   = 4'd5;
  localparam logic [PhaseW-1:0] PH_CLOSE  = 4'd6;
  localparam logic [PhaseW-1:0] PH_DWELL  = 4'd7;
  localparam logic [PhaseW-1:0] PH_LOCK   = 4'd8;

  // Option bytes
  localparam logic [DataW-1:0] OPT_OPEN   = 8'h2B;
  localparam logic [DataW-1:0] OPT_CHANGE = 8'h2D;

  // Item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Motor commands
  localparam logic [1:0] MOTOR_STOP  = 2'd0;
  localparam logic [1:0] MOTOR_OPEN  = 2'd1;
  localparam logic [1:0] MOTOR_CLOSE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_OPEN_TICKS    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CLOSE_TICKS   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DWELL_TICKS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOCKOUT_TICKS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_WRONG     = 3'd5;

  // Configuration reset values
  localparam logic [TickW-1:0]  OPEN_TICKS_RST    = 8'd59;
  localparam logic [TickW-1:0]  HOLD_TICKS_RST    = 8'd12;
  localparam logic [TickW-1:0]  CLOSE_TICKS_RST   = 8'd59;
  localparam logic [TickW-1:0]  DWELL_TICKS_RST   = 8'd8;
  localparam logic [TickW-1:0]  LOCKOUT_TICKS_RST = 8'd235;
  localparam logic [WrongW-1:0] MAX_WRONG_RST     = 3'd3;

  // One result record
  typedef struct packed {
    logic              reply_valid;
    logic              reply_ok;
    logic [1:0]        motor_drive;
    logic              alarm;
    logic [PhaseW-1:0] phase;
  } res_t;

endpackage

@@ src/code_lock_door_controller.sv @@
// ----------------------------------------------------------------------------
// code_lock_door_controller
// Code lock controller driven by keypad bytes and timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_func, in_data) carries one keypad
//   byte (in_func = 0) or one timer tick (in_func = 1) per transaction.
//   Result channel (out_valid/out_ready) returns exactly one result per input
//   transaction: reply flag and value, motor command, alarm and phase.
//   Configuration (cfg_we, cfg_idx, cfg_wdata) writes the tick counts and the
//   wrong entry limit; write only while no transaction is in flight.
//   A result is registered as its input is accepted (skid register if one
//   waits). Throughput: one transaction per cycle while in_ready is high; the
//   phase, counters and code banks update with it, so the next item sees them.
//   A two-entry output buffer (result register plus skid register) lets one
//   more transaction in while a result waits; in_ready drops only when both
//   entries are full, and rises again once the receiver takes a result.
//   Reset: phase returns to set-password first entry, counters clear,
//   registers return to their defaults. Code storage is not cleared; it is
//   always written before it is read.
// ----------------------------------------------------------------------------
module code_lock_door_controller #(
  parameter int CODE_LEN = cldc_pkg::CodeLenDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [cldc_pkg::DataW-1:0]   in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_reply_valid,
  output logic                         out_reply_ok,
  output logic [1:0]                   out_motor_drive,
  output logic                         out_alarm,
  output logic [cldc_pkg::PhaseW-1:0]  out_phase,
  // configuration
  input  logic                         cfg_we,
  input  logic [cldc_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [cldc_pkg::CfgW-1:0]    cfg_wdata
);
  import cldc_pkg::*;

  localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CODE_LEN - 1);

  // configuration registers
  logic [TickW-1:0]  open_ticks_r, hold_ticks_r, close_ticks_r;
  logic [TickW-1:0]  dwell_ticks_r, lockout_ticks_r;
  logic [WrongW-1:0] max_wrong_r;

  // control state
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              mis_r, mis_nxt;
  logic [TickW-1:0]  tick_r, tick_nxt;
  logic [WrongW-1:0] wrong_r, wrong_nxt;
  logic              pend_r, pend_nxt;
  logic              bank_r, bank_nxt;

  // two code banks: bank_r holds the stored code, the other takes new entries
  logic [DataW-1:0]  code_mem_r [2][CODE_LEN];

  // output buffer
  logic              main_valid_r, skid_valid_r;
  res_t              main_r, skid_r;

  // datapath
  logic              accept, out_take;
  logic              last;
  logic              rd_bank;
  logic [DataW-1:0]  rd_data;
  logic              mis_now;
  logic              mem_we;
  logic [TickW-1:0]  tick_inc, tick_limit;
  logic [WrongW-1:0] wrong_inc;
  logic              rv, ok;
  res_t              res;

  assign accept   = in_valid && in_ready;
  assign out_take = main_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  // read the stored bank when checking, the entry bank otherwise
  assign last      = (idx_r == IDX_LAST);
  assign rd_bank   = (phase_r == PH_CHECK) ? bank_r : !bank_r;
  assign rd_data   = code_mem_r[rd_bank][idx_r];
  assign mis_now   = mis_r || (rd_data != in_data);
  assign tick_inc  = tick_r + 8'd1;
  assign wrong_inc = wrong_r + 3'd1;

  // pick the tick limit of the current timed phase
  always_comb begin
    unique case (phase_r)
      PH_OPEN:  tick_limit = open_ticks_r;
      PH_HOLD:  tick_limit = hold_ticks_r;
      PH_CLOSE: tick_limit = close_ticks_r;
      PH_DWELL: tick_limit = dwell_ticks_r;
      default:  tick_limit = lockout_ticks_r;
    endcase
  end

  // next state for one transaction
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    mis_nxt   = mis_r;
    tick_nxt  = tick_r;
    wrong_nxt = wrong_r;
    pend_nxt  = pend_r;
    bank_nxt  = bank_r;
    mem_we    = 1'b0;
    rv        = 1'b0;
    ok        = 1'b0;
    if (in_func == FUNC_BYTE) begin
      unique case (phase_r)
        PH_SET1: begin
          mem_we = 1'b1;
          if (last) begin
            phase_nxt = PH_SET2;
            idx_nxt   = '0;
            mis_nxt   = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        PH_SET2: begin
          if (!last) begin
            idx_nxt = idx_r + 1'b1;
            mis_nxt = mis_now;
          end else begin
            rv      = 1'b1;
            idx_nxt = '0;
            mis_nxt = 1'b0;
            if (!mis_now) begin
              ok        = 1'b1;
              bank_nxt  = !bank_r;
              phase_nxt = PH_OPTION;
            end else begin
              phase_nxt = PH_SET1;
            end
          end
        end
        PH_OPTION: begin
          if (in_data == OPT_OPEN || in_data == OPT_CHANGE) begin
            pend_nxt  = (in_data == OPT_CHANGE);
            phase_nxt = PH_CHECK;
            idx_nxt   = '0;
            mis_nxt   = 1'b0;
          end
        end
        PH_CHECK: begin
          if (!last) begin
            idx_nxt = idx_r + 1'b1;
            mis_nxt = mis_now;
          end else begin
            rv      = 1'b1;
            idx_nxt = '0;
            mis_nxt = 1'b0;
            if (!mis_now) begin
              ok        = 1'b1;
              wrong_nxt = '0;
              if (pend_r) begin
                phase_nxt = PH_SET1;
              end else begin
                phase_nxt = PH_OPEN;
                tick_nxt  = '0;
              end
            end else begin
              wrong_nxt = wrong_inc;
              if (wrong_inc == '0 || wrong_inc >= max_wrong_r) begin
                phase_nxt = PH_LOCK;
                tick_nxt  = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      // count ticks in the timed phases
      if (phase_r >= PH_OPEN && phase_r <= PH_LOCK) begin
        tick_nxt = tick_inc;
        if (tick_inc >= tick_limit) begin
          tick_nxt = '0;
          unique case (phase_r)
            PH_OPEN:  phase_nxt = PH_HOLD;
            PH_HOLD:  phase_nxt = PH_CLOSE;
            PH_CLOSE: phase_nxt = PH_DWELL;
            PH_DWELL: begin
              phase_nxt = PH_OPTION;
              idx_nxt   = '0;
              mis_nxt   = 1'b0;
            end
            default: begin
              phase_nxt = PH_OPTION;
              idx_nxt   = '0;
              mis_nxt   = 1'b0;
              wrong_nxt = '0;
            end
          endcase
        end
      end
    end
  end

  // build the result record from the new phase
  always_comb begin
    res.reply_valid = rv;
    res.reply_ok    = ok;
    res.alarm       = (phase_nxt == PH_LOCK);
    res.phase       = phase_nxt;
    if (phase_nxt == PH_OPEN) begin
      res.motor_drive = MOTOR_OPEN;
    end else if (phase_nxt == PH_CLOSE) begin
      res.motor_drive = MOTOR_CLOSE;
    end else begin
      res.motor_drive = MOTOR_STOP;
    end
  end

  // advance control state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SET1;
      idx_r   <= '0;
      mis_r   <= 1'b0;
      tick_r  <= '0;
      wrong_r <= '0;
      pend_r  <= 1'b0;
      bank_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      mis_r   <= mis_nxt;
      tick_r  <= tick_nxt;
      wrong_r <= wrong_nxt;
      pend_r  <= pend_nxt;
      bank_r  <= bank_nxt;
    end
  end

  // write entry characters into the free bank
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      code_mem_r[!bank_r][idx_r] <= in_data;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_ticks_r    <= OPEN_TICKS_RST;
      hold_ticks_r    <= HOLD_TICKS_RST;
      close_ticks_r   <= CLOSE_TICKS_RST;
      dwell_ticks_r   <= DWELL_TICKS_RST;
      lockout_ticks_r <= LOCKOUT_TICKS_RST;
      max_wrong_r     <= MAX_WRONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OPEN_TICKS:    open_ticks_r    <= cfg_wdata;
        REG_HOLD_TICKS:    hold_ticks_r    <= cfg_wdata;
        REG_CLOSE_TICKS:   close_ticks_r   <= cfg_wdata;
        REG_DWELL_TICKS:   dwell_ticks_r   <= cfg_wdata;
        REG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_wdata;
        REG_MAX_WRONG:     max_wrong_r     <= cfg_wdata[WrongW-1:0];
        default: begin
        end
      endcase
    end
  end

  // output buffer valid flags: main register first, skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!main_valid_r || out_take) begin
        main_valid_r <= skid_valid_r || accept;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (!main_valid_r || out_take) begin
      main_r <= skid_valid_r ? skid_r : res;
    end
    if (main_valid_r && !out_take && accept) begin
      skid_r <= res;
    end
  end

  assign out_valid       = main_valid_r;
  assign out_reply_valid = main_r.reply_valid;
  assign out_reply_ok    = main_r.reply_ok;
  assign out_motor_drive = main_r.motor_drive;
  assign out_alarm       = main_r.alarm;
  assign out_phase       = main_r.phase;

  // skid entry is only ever filled behind a full main register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid register full while result register empty");

  // a reply only comes with a phase that ends an entry
  a_reply_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && main_r.reply_valid) |->
      (main_r.phase == PH_SET1 || main_r.phase == PH_OPTION ||
       main_r.phase == PH_CHECK || main_r.phase == PH_OPEN ||
       main_r.phase == PH_LOCK))
    else $error("reply with unexpected phase");

  // success never reported without a reply
  a_ok_needs_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && main_r.reply_ok) |-> main_r.reply_valid)
    else $error("reply_ok without reply_valid");

  // character index stays inside the entry
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("character index beyond code length");

  // a held result stays put while the receiver stalls
  a_main_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && !out_ready) |=> (main_valid_r && $stable(main_r)))
    else $error("stalled result changed");

endmodule

@@ dv/code_lock_door_controller_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_lock_door_controller_test
// Self-checking testbench for the code lock door controller. A cycle-free
// model of the controller predicts one result per accepted transaction, and
// every result is compared in order against it. Directed tests cover the
// default timing and the register extremes. Later tests cover a long receiver
// stall and phase-aware random traffic under several register settings, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module code_lock_door_controller_test;
  import cldc_pkg::*;

  localparam int CodeLen     = CodeLenDef;
  localparam int CycleLimit  = 800000;
  localparam int RandomItems = 300;
  localparam int RandomSets  = 6;
  localparam int ReportMax   = 10;

  typedef logic [CodeLen-1:0][DataW-1:0]      code_t;
  typedef logic [REG_MAX_WRONG:0][CfgW-1:0]   setting_t;

  // Block ports
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic                in_func   = FUNC_BYTE;
  logic [DataW-1:0]    in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_reply_valid;
  logic                out_reply_ok;
  logic [1:0]          out_motor_drive;
  logic                out_alarm;
  logic [PhaseW-1:0]   out_phase;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgW-1:0]     cfg_wdata = '0;

  // Idling controls
  logic steady   = 1'b0;
  int   hold_len = 0;
  int   hold_id  = 0;
  int   sink_hold_seen = 0;
  int   sink_hold_left = 0;
  int   sink_stall     = 0;

  // Controller model state and settings
  logic [TickW-1:0]  open_limit, hold_limit, close_limit, dwell_limit, lockout_limit;
  logic [WrongW-1:0] wrong_limit;
  code_t             saved_code, first_code;
  int                char_idx;
  logic              entry_bad;
  logic [PhaseW-1:0] lock_phase;
  logic [TickW-1:0]  tick_cnt;
  logic [WrongW-1:0] wrong_cnt;
  logic              change_pending;
  logic              item_ignored;

  // Results still owed by the block, oldest first
  res_t door_results_due[$];

  // Run statistics
  int failures = 0;
  int cycle_count = 0;
  int useful_items = 0;
  int bytes_sent = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  int codes_stored = 0;
  int doors_opened = 0;
  int lockouts = 0;
  int replies_ok = 0;
  int replies_bad = 0;

  code_lock_door_controller #(
    .CODE_LEN(CodeLen)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reply_valid (out_reply_valid),
    .out_reply_ok    (out_reply_ok),
    .out_motor_drive (out_motor_drive),
    .out_alarm       (out_alarm),
    .out_phase       (out_phase),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Controller model
  // ---------------------------------------------------------------------------
  function automatic void reset_model();
    open_limit     = OPEN_TICKS_RST;
    hold_limit     = HOLD_TICKS_RST;
    close_limit    = CLOSE_TICKS_RST;
    dwell_limit    = DWELL_TICKS_RST;
    lockout_limit  = LOCKOUT_TICKS_RST;
    wrong_limit    = MAX_WRONG_RST;
    saved_code     = '0;
    first_code     = '0;
    char_idx       = 0;
    entry_bad      = 1'b0;
    lock_phase     = PH_SET1;
    tick_cnt       = '0;
    wrong_cnt      = '0;
    change_pending = 1'b0;
  endfunction

  function automatic void apply_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgW-1:0] value);
    case (idx)
      REG_OPEN_TICKS:    open_limit    = value;
      REG_HOLD_TICKS:    hold_limit    = value;
      REG_CLOSE_TICKS:   close_limit   = value;
      REG_DWELL_TICKS:   dwell_limit   = value;
      REG_LOCKOUT_TICKS: lockout_limit = value;
      REG_MAX_WRONG:     wrong_limit   = value[WrongW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void begin_entry(input logic [PhaseW-1:0] ph);
    lock_phase = ph;
    char_idx   = 0;
    entry_bad  = 1'b0;
  endfunction

  function automatic void begin_timed(input logic [PhaseW-1:0] ph);
    lock_phase = ph;
    tick_cnt   = '0;
  endfunction

  // Count one tick; a limit of zero expires on the first tick
  function automatic logic tick_expired(input logic [TickW-1:0] limit);
    tick_cnt = tick_cnt + 1'b1;
    return tick_cnt >= limit;
  endfunction

  // Advance the model by one transaction and return the result it causes
  function automatic res_t next_door_result(input logic f, input logic [DataW-1:0] d);
    res_t r;
    logic last;
    r = '0;
    item_ignored = 1'b0;
    last = (char_idx == CodeLen - 1);
    if (f == FUNC_TICK) begin
      case (lock_phase)
        PH_OPEN:  if (tick_expired(open_limit)) begin_timed(PH_HOLD);
        PH_HOLD:  if (tick_expired(hold_limit)) begin_timed(PH_CLOSE);
        PH_CLOSE: if (tick_expired(close_limit)) begin_timed(PH_DWELL);
        PH_DWELL: begin
          if (tick_expired(dwell_limit)) begin
            tick_cnt = '0;
            begin_entry(PH_OPTION);
          end
        end
        PH_LOCK: begin
          if (tick_expired(lockout_limit)) begin
            tick_cnt  = '0;
            wrong_cnt = '0;
            begin_entry(PH_OPTION);
          end
        end
        default: item_ignored = 1'b1;
      endcase
    end else begin
      case (lock_phase)
        PH_SET1: begin
          first_code[char_idx] = d;
          if (last) begin_entry(PH_SET2);
          else char_idx++;
        end
        PH_SET2: begin
          if (first_code[char_idx] != d) entry_bad = 1'b1;
          if (!last) begin
            char_idx++;
          end else begin
            r.reply_valid = 1'b1;
            r.reply_ok    = !entry_bad;
            if (!entry_bad) begin
              saved_code = first_code;
              codes_stored++;
              begin_entry(PH_OPTION);
            end else begin
              begin_entry(PH_SET1);
            end
          end
        end
        PH_OPTION: begin
          if (d == OPT_OPEN) begin
            change_pending = 1'b0;
            begin_entry(PH_CHECK);
          end else if (d == OPT_CHANGE) begin
            change_pending = 1'b1;
            begin_entry(PH_CHECK);
          end else begin
            item_ignored = 1'b1;
          end
        end
        PH_CHECK: begin
          if (saved_code[char_idx] != d) entry_bad = 1'b1;
          if (!last) begin
            char_idx++;
          end else begin
            r.reply_valid = 1'b1;
            r.reply_ok    = !entry_bad;
            if (!entry_bad) begin
              wrong_cnt = '0;
              if (change_pending) begin
                begin_entry(PH_SET1);
              end else begin
                begin_entry(PH_OPEN);
                begin_timed(PH_OPEN);
                doors_opened++;
              end
            end else begin
              // count wraps in three bits; a zero limit locks on the first miss
              wrong_cnt = wrong_cnt + 1'b1;
              if (wrong_cnt == '0 || wrong_cnt >= wrong_limit) begin
                begin_entry(PH_LOCK);
                begin_timed(PH_LOCK);
                lockouts++;
              end else begin
                begin_entry(PH_CHECK);
              end
            end
          end
        end
        default: item_ignored = 1'b1;
      endcase
    end
    if (r.reply_valid) begin
      if (r.reply_ok) replies_ok++;
      else replies_bad++;
    end
    r.motor_drive = (lock_phase == PH_OPEN)  ? MOTOR_OPEN :
                    (lock_phase == PH_CLOSE) ? MOTOR_CLOSE : MOTOR_STOP;
    r.alarm       = (lock_phase == PH_LOCK);
    r.phase       = lock_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string what);
    failures++;
    if (failures <= ReportMax) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Offer one transaction, hold it until accepted, then predict its result
  task automatic send_item(input logic f, input logic [DataW-1:0] d);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    door_results_due.push_back(next_door_result(f, d));
    if (!item_ignored) useful_items++;
    if (f == FUNC_TICK) ticks_sent++;
    else bytes_sent++;
  endtask

  task automatic send_code(input code_t c);
    for (int k = 0; k < CodeLen; k++) send_item(FUNC_BYTE, c[k]);
  endtask

  task automatic send_ticks(input int n);
    for (int k = 0; k < n; k++) send_item(FUNC_TICK, DataW'($urandom));
  endtask

  // Drop valid and let every owed result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (door_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write every register once, one per cycle
  task automatic write_settings(input setting_t v);
    for (int k = 0; k <= int'(REG_MAX_WRONG); k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgIdxW'(k);
      cfg_wdata <= v[k];
      @(posedge clk);
      apply_setting(CfgIdxW'(k), v[k]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic setting_t random_setting();
    setting_t v;
    for (int k = 0; k < int'(REG_MAX_WRONG); k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: v[k] = '0;
        3, 4:    v[k] = CfgW'($urandom_range(5, 40));
        default: v[k] = CfgW'($urandom_range(1, 4));
      endcase
    end
    // upper bits of the limit are don't-care
    v[REG_MAX_WRONG] = CfgW'($urandom);
    return v;
  endfunction

  function automatic code_t random_code();
    code_t c;
    for (int k = 0; k < CodeLen; k++) c[k] = DataW'($urandom);
    return c;
  endfunction

  // Flip at least one bit of one character
  function automatic code_t corrupt_code(input code_t c);
    code_t w;
    int pos;
    w = c;
    pos = $urandom_range(0, CodeLen - 1);
    w[pos] = w[pos] ^ DataW'($urandom_range(1, 255));
    return w;
  endfunction

  // Send one phase-aware chunk: mostly well-formed entries, some noise
  task automatic random_traffic();
    code_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (char_idx != 0) begin
      // finish an entry left partway
      send_item(FUNC_BYTE, DataW'($urandom));
    end else begin
      case (lock_phase)
        PH_SET1: begin
          if (roll < 10) begin
            send_item(FUNC_TICK, DataW'($urandom));
          end else begin
            c = random_code();
            send_code(c);
            send_code(roll < 25 ? corrupt_code(c) : c);
          end
        end
        PH_SET2: send_code(roll < 60 ? first_code : random_code());
        PH_OPTION: begin
          if (roll < 8) send_item(FUNC_TICK, DataW'($urandom));
          else if (roll < 16) send_item(FUNC_BYTE, DataW'($urandom));
          else if (roll < 40) send_item(FUNC_BYTE, OPT_CHANGE);
          else send_item(FUNC_BYTE, OPT_OPEN);
        end
        PH_CHECK: begin
          if (roll < 8) send_item(FUNC_TICK, DataW'($urandom));
          else if (roll < 22) send_code(random_code());
          else if (roll < 40) send_code(corrupt_code(saved_code));
          else send_code(saved_code);
        end
        default: begin
          // timed phases: ticks, with a few bytes that must be ignored
          if (roll < 10) send_item(FUNC_BYTE, DataW'($urandom));
          else send_item(FUNC_TICK, DataW'($urandom));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset timing: set-password paths, options, a full door cycle and a lockout
  task automatic test_default_timing();
    code_t a;
    a = {8'h00, 8'hFF, 8'h5A, 8'hA5, OPT_OPEN};
    send_item(FUNC_TICK, 8'hFF);           // tick outside timed phases
    send_code(a);
    send_code(corrupt_code(a));            // second entry differs
    send_code(a);
    send_code(a);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_BYTE, 8'hFF);           // unknown option bytes
    send_item(FUNC_BYTE, 8'h2C);
    send_item(FUNC_BYTE, OPT_OPEN);
    send_code(corrupt_code(a));            // miss, stays in code check
    send_code(a);
    send_item(FUNC_BYTE, OPT_CHANGE);      // byte while opening
    send_ticks(int'(OPEN_TICKS_RST));
    send_item(FUNC_BYTE, OPT_OPEN);        // byte while holding
    send_ticks(int'(HOLD_TICKS_RST) + int'(CLOSE_TICKS_RST) + int'(DWELL_TICKS_RST) - 1);
    send_item(FUNC_BYTE, 8'h00);           // byte during dwell
    send_ticks(1);
    send_item(FUNC_BYTE, OPT_CHANGE);
    repeat (int'(MAX_WRONG_RST)) send_code(corrupt_code(a));
    send_item(FUNC_BYTE, OPT_OPEN);        // byte during lockout
    send_ticks(int'(LOCKOUT_TICKS_RST));
    send_item(FUNC_BYTE, OPT_CHANGE);
    send_code(a);
    send_code('1);
    send_code('1);
  endtask

  // Zero, full-scale and masked register values
  task automatic test_register_extremes();
    setting_t v;
    wait_idle();
    write_settings('0);
    send_item(FUNC_BYTE, OPT_OPEN);
    send_code(saved_code);
    send_ticks(4);
    send_item(FUNC_BYTE, OPT_OPEN);
    send_code(corrupt_code(saved_code));   // zero limit locks at once
    send_ticks(1);

    // full scale on open, lockout and the wrong limit
    wait_idle();
    v = '1;
    v[REG_HOLD_TICKS]  = 8'h01;
    v[REG_CLOSE_TICKS] = 8'h01;
    v[REG_DWELL_TICKS] = 8'h01;
    write_settings(v);
    send_item(FUNC_BYTE, OPT_OPEN);
    send_code(saved_code);
    send_ticks(255 + 3);
    send_item(FUNC_BYTE, OPT_CHANGE);
    repeat (7) send_code(corrupt_code(saved_code));
    send_ticks(255);

    wait_idle();
    v = {6{8'h01}};
    v[REG_MAX_WRONG] = 8'hFA;
    write_settings(v);
    send_item(FUNC_BYTE, OPT_OPEN);
    repeat (2) send_code(corrupt_code(saved_code));
    send_ticks(1);
    send_item(FUNC_BYTE, OPT_OPEN);
    send_code(saved_code);
    send_ticks(4);
    send_item(FUNC_BYTE, OPT_CHANGE);
    send_code(saved_code);
  endtask

  // Stall the receiver while transactions keep coming
  task automatic test_receiver_backpressure();
    steady   <= 1'b1;
    hold_len <= 64;
    hold_id  <= hold_id + 1;
    repeat (40) random_traffic();
    steady   <= 1'b0;
  endtask

  // Random traffic under several random settings, one set without gaps
  task automatic test_random_traffic();
    int goal;
    for (int p = 0; p < RandomSets; p++) begin
      wait_idle();
      write_settings(random_setting());
      steady <= (p == 2);
      goal = useful_items + RandomItems / RandomSets;
      while (useful_items < goal) random_traffic();
    end
    steady <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus a long hold on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_sink
    if (hold_id != sink_hold_seen) begin
      sink_hold_seen = hold_id;
      sink_hold_left = hold_len;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady) sink_stall = pick_gap();
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_reply_valid, out_reply_ok, out_motor_drive, out_alarm, out_phase};
      if (door_results_due.size() == 0) begin
        note_failure("result with no transaction outstanding");
      end else begin
        want = door_results_due.pop_front();
        if (got !== want) begin
          note_failure($sformatf(
            "exp/got phase %0d/%0d motor %0d/%0d alarm %0b/%0b reply %0b/%0b ok %0b/%0b",
            want.phase, got.phase, want.motor_drive, got.motor_drive,
            want.alarm, got.alarm, want.reply_valid, got.reply_valid,
            want.reply_ok, got.reply_ok));
        end
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed",
             cycle_count, door_results_due.size());
    $display("FAIL code_lock_door_controller");
    $finish;
  end

  initial begin : test_sequence
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    reset_model();
    test_default_timing();
    test_register_extremes();
    test_receiver_backpressure();
    test_random_traffic();
    wait_idle();
    $display("Ran %0d keypad bytes and %0d ticks under %0d register settings in %0d cycles.",
             bytes_sent, ticks_sent, settings_used, cycle_count);
    $display("Codes stored %0d, doors cycled %0d, lockouts %0d, replies %0d ok / %0d bad.",
             codes_stored, doors_opened, lockouts, replies_ok, replies_bad);
    if (failures == 0 && door_results_due.size() == 0) begin
      $display("PASS code_lock_door_controller");
    end else begin
      $display("%0d mismatches, %0d results missing", failures, door_results_due.size());
      $display("FAIL code_lock_door_controller");
    end
    $finish;
  end

endmodule
